FILE: design/tsba_pkg.sv
// tsba_pkg: shared constants, codes and types of the slot bitmap allocator
// depends on nothing; used by every other file of the block
`default_nettype none

package tsba_pkg;

    localparam int SLOT_COUNT  = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(SLOT_COUNT);

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 6;

    typedef logic [IDX_W-1:0]       slot_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [SLOT_COUNT-1:0]  slot_map_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_GET   = 2'd2,
        OP_SET   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPARAM = 2'd2
    } status_t;

    // request from the allocator to the value store
    typedef struct packed {
        logic   wr_en;
        logic   clr_en;
        logic   rd_en;
        slot_t  slot;
        value_t data;
    } store_req_t;

    typedef struct packed {
        logic  found;
        slot_t slot;
    } free_search_t;

    // lowest clear bit of the used map
    function automatic free_search_t find_first_free(slot_map_t used);
        free_search_t res;
        res.found = 1'b0;
        res.slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                res.found = 1'b1;
                res.slot  = slot_t'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/tsba_req_if.sv
// tsba_req_if: request channel of the slot bitmap allocator
// depends on tsba_pkg for field widths
`default_nettype none

interface tsba_req_if;
    logic                         valid;
    logic                         ready;
    logic [tsba_pkg::OP_W-1:0]    operation;
    logic [tsba_pkg::INDEX_W-1:0] slot_index;
    logic [tsba_pkg::DATA_W-1:0]  slot_value;

    modport source (output valid, output operation, output slot_index,
                    output slot_value, input ready);
    modport sink   (input valid, input operation, input slot_index,
                    input slot_value, output ready);
endinterface

`default_nettype wire

FILE: design/tsba_rsp_if.sv
// tsba_rsp_if: result channel of the slot bitmap allocator
// depends on tsba_pkg for field widths
`default_nettype none

interface tsba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tsba_pkg::STATUS_W-1:0] status;
    logic [tsba_pkg::GRANT_W-1:0]  granted_index;
    logic [tsba_pkg::DATA_W-1:0]   read_value;

    modport source (output valid, output status, output granted_index,
                    output read_value, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input read_value, output ready);
endinterface

`default_nettype wire

FILE: design/tsba_slot_store.sv
// tsba_slot_store: per-slot value memory with a valid bit per slot
// depends on tsba_pkg; an invalid slot reads as zero
`default_nettype none

module tsba_slot_store (
    input  wire                  clk,
    input  wire                  rst_n,
    input  tsba_pkg::store_req_t req,
    output tsba_pkg::value_t     rd_data
);

    tsba_pkg::value_t    mem [tsba_pkg::SLOT_COUNT];
    tsba_pkg::slot_map_t valid_reg;
    tsba_pkg::slot_map_t valid_next;
    tsba_pkg::value_t    rd_data_reg;
    logic                rd_hit_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.slot] = 1'b1;
        end
        if (req.clr_en)
        begin
            valid_next[req.slot] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.slot] <= req.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.slot];
            rd_hit_reg  <= valid_reg[req.slot];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: design/tls_slot_bitmap_allocator_unit.sv
// tls_slot_bitmap_allocator_unit: 64-slot first-free allocator with value store
// depends on tsba_pkg, tsba_req_if, tsba_rsp_if and tsba_slot_store
//
// usage
//   req carries operation, slot_index and slot_value; rsp returns status,
//   granted_index and read_value, one result per request, in order
//   alloc grants the lowest free slot; free, get and set address a slot
//   a transfer happens on a rising edge with valid and ready both high
// timing
//   a request's result is valid in the cycle after its transfer
//   one request per cycle while rsp is not stalled, set by the single output register stage
//   the used map and value store update at the request's transfer, so the
//   next request sees them with no gap
// reset
//   asynchronous, active low; all slots free, all values read as zero,
//   rsp.valid low; no clearing pass is needed
// stall
//   while rsp is held, req.ready stays low until the result is taken, and
//   in the cycle it is taken a new request can transfer
`default_nettype none

module tls_slot_bitmap_allocator_unit (
    input  wire         clk,
    input  wire         rst_n,
    tsba_req_if.sink    req,
    tsba_rsp_if.source  rsp
);

    tsba_pkg::slot_map_t    used_reg;
    tsba_pkg::slot_map_t    used_next;
    tsba_pkg::free_search_t free_slot;
    tsba_pkg::store_req_t   store_req;
    tsba_pkg::value_t       store_data;
    tsba_pkg::op_t          op;
    tsba_pkg::slot_t        slot;
    tsba_pkg::status_t      status_next;
    tsba_pkg::status_t      status_reg;
    logic [tsba_pkg::GRANT_W-1:0] granted_next;
    logic [tsba_pkg::GRANT_W-1:0] granted_reg;
    logic                   get_ok_next;
    logic                   get_ok_reg;
    logic                   out_valid_reg;
    logic                   in_range;
    logic                   accept;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign op        = tsba_pkg::op_t'(req.operation);
    assign slot      = req.slot_index[tsba_pkg::IDX_W-1:0];
    assign in_range  = {1'b0, req.slot_index} < (tsba_pkg::INDEX_W + 1)'(tsba_pkg::SLOT_COUNT);
    assign free_slot = tsba_pkg::find_first_free(used_reg);

    always_comb
    begin
        used_next       = used_reg;
        status_next     = tsba_pkg::ST_OK;
        granted_next    = '0;
        get_ok_next     = 1'b0;
        store_req.wr_en  = 1'b0;
        store_req.clr_en = 1'b0;
        store_req.rd_en  = 1'b0;
        store_req.slot   = slot;
        store_req.data   = tsba_pkg::value_t'(req.slot_value);
        unique case (op)
            tsba_pkg::OP_ALLOC:
            begin
                if (free_slot.found)
                begin
                    used_next[free_slot.slot] = accept;
                    granted_next = tsba_pkg::GRANT_W'(free_slot.slot);
                end
                else
                begin
                    status_next = tsba_pkg::ST_FULL;
                end
            end
            tsba_pkg::OP_FREE:
            begin
                if (!in_range || !used_reg[slot])
                begin
                    status_next = tsba_pkg::ST_BADPARAM;
                end
                else
                begin
                    used_next[slot]  = !accept;
                    store_req.clr_en = accept;
                end
            end
            tsba_pkg::OP_GET:
            begin
                if (!in_range)
                begin
                    status_next = tsba_pkg::ST_BADPARAM;
                end
                else
                begin
                    get_ok_next     = 1'b1;
                    store_req.rd_en = accept;
                end
            end
            tsba_pkg::OP_SET:
            begin
                if (!in_range)
                begin
                    status_next = tsba_pkg::ST_BADPARAM;
                end
                else
                begin
                    store_req.wr_en = accept;
                end
            end
            default:
            begin
                status_next = tsba_pkg::ST_BADPARAM;
            end
        endcase
    end

    tsba_slot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (store_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            get_ok_reg  <= get_ok_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.granted_index = granted_reg;
    assign rsp.read_value    = get_ok_reg ? tsba_pkg::DATA_W'(store_data) : '0;

endmodule

`default_nettype wire

FILE: design/tsba_checker.sv
// tsba_checker: port-level assertions for the slot bitmap allocator
// depends on tsba_pkg; bound to tls_slot_bitmap_allocator_unit below
`default_nettype none

module tsba_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                req_valid,
    input wire                                req_ready,
    input wire                                rsp_valid,
    input wire                                rsp_ready,
    input wire [tsba_pkg::STATUS_W-1:0]       rsp_status,
    input wire [tsba_pkg::GRANT_W-1:0]        rsp_granted_index,
    input wire [tsba_pkg::DATA_W-1:0]         rsp_read_value
);

    // every request transfer gives a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("request transfer without following result");

    // a failed request grants nothing and returns no data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != tsba_pkg::ST_OK |->
            rsp_granted_index == '0 && rsp_read_value == '0)
        else $error("failed request carries grant or data");

    // request side only stalls behind a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid)
        else $error("request side stalled with no pending result");

    // result holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_status) && $stable(rsp_granted_index)
            && $stable(rsp_read_value))
        else $error("stalled result changed");

endmodule

bind tls_slot_bitmap_allocator_unit tsba_checker u_tsba_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_granted_index (rsp.granted_index),
    .rsp_read_value    (rsp.read_value)
);

`default_nettype wire
